@@ sv/assert_macros.svh @@
// assertion macros for the rtl files
// depends on nothing; each file that asserts includes it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// clocked implication checked in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

@@ sv/sga_pkg.sv @@
// types and constants of the strided gather address generator
// depends on nothing
package sga_pkg;

    localparam int LIN_BITS      = 32;
    localparam int DIV_STEP_BITS = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RANK          = 3'd0,
        CFG_SHAPE         = 3'd1,
        CFG_STRIDE        = 3'd2,
        CFG_BASE_OFFSET   = 3'd3,
        CFG_ELEMENT_COUNT = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [LIN_BITS-1:0] lin;
        logic                beyond;
    } item_t;

endpackage

@@ sv/strided_gather_address.sv @@
// top level of the strided gather address generator: config registers and dimension chain
// depends on sga_pkg, sga_dim_unit and assert_macros.svh
//
// One address per cycle: a new linear index is taken every cycle while the output is
// taken or empty. Each dimension runs an eight-stage divider retiring four quotient
// bits per stage, then a multiply stage and an accumulate stage. The result sits in
// the last accumulate register; a stall holds the whole pipeline. Configuration is
// written through the cfg port, always ready; the stages read it live, so write it
// only while no beat is in flight.
`include "assert_macros.svh"

module strided_gather_address #(
    parameter int MAX_RANK   = 4,
    parameter int DIM_BITS   = 16,
    parameter int INDEX_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sga_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [sga_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [31:0]                       linear_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [31:0]                       dest_index,
    output logic [31:0]                       src_index,
    output logic                              beyond_end,
    output logic                              overflow
);

    localparam int PROD_BITS = 2 * DIM_BITS;
    localparam int SUM_BITS  = ((32 > PROD_BITS) ? 32 : PROD_BITS) + 3;
    localparam int LB        = sga_pkg::LIN_BITS;

    logic [2:0]  rank_reg;
    logic [63:0] shape_reg;
    logic [63:0] stride_reg;
    logic [31:0] base_offset_reg;
    logic [31:0] element_count_reg;

    logic [2:0]          used;
    logic [DIM_BITS-1:0] slot_size   [MAX_RANK];
    logic [DIM_BITS-1:0] slot_stride [MAX_RANK];

    logic                advance;
    logic                chain_valid [MAX_RANK+1];
    sga_pkg::item_t      chain_item  [MAX_RANK+1];
    logic [LB-1:0]       chain_rem   [MAX_RANK+1];
    logic [SUM_BITS-1:0] chain_sum   [MAX_RANK+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg          <= 3'd1;
            shape_reg         <= 64'h0001_0001_0001_0001;
            stride_reg        <= '0;
            base_offset_reg   <= '0;
            element_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sga_pkg::CFG_RANK:          rank_reg          <= cfg_data[2:0];
                sga_pkg::CFG_SHAPE:         shape_reg         <= cfg_data;
                sga_pkg::CFG_STRIDE:        stride_reg        <= cfg_data;
                sga_pkg::CFG_BASE_OFFSET:   base_offset_reg   <= cfg_data[31:0];
                sga_pkg::CFG_ELEMENT_COUNT: element_count_reg <= cfg_data[31:0];
                default:                    ;
            endcase
        end
    end

    // innermost used dimension goes to the first slot
    always_comb
    begin
        used = (rank_reg > 3'(MAX_RANK)) ? 3'(MAX_RANK) : rank_reg;
        for (int j = 0; j < MAX_RANK; j++)
        begin
            slot_size[j]   = DIM_BITS'(1);
            slot_stride[j] = '0;
            for (int d = 0; d < MAX_RANK; d++)
            begin
                if ((3'(j) < used) && (3'(d) == used - 3'd1 - 3'(j)))
                begin
                    slot_size[j]   = shape_reg[d*DIM_BITS +: DIM_BITS];
                    slot_stride[j] = stride_reg[d*DIM_BITS +: DIM_BITS];
                end
            end
            if (slot_size[j] == '0)
            begin
                slot_size[j] = DIM_BITS'(1);
            end
        end
    end

    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    assign chain_valid[0]       = in_valid;
    assign chain_item[0].lin    = linear_index;
    assign chain_item[0].beyond = (linear_index >= element_count_reg);
    assign chain_rem[0]         = linear_index;
    assign chain_sum[0]         = SUM_BITS'(base_offset_reg);

    for (genvar j = 0; j < MAX_RANK; j++)
    begin : g_dim
        sga_dim_unit #(
            .DIM_BITS (DIM_BITS),
            .SUM_BITS (SUM_BITS)
        ) u_dim (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[j]),
            .in_item   (chain_item[j]),
            .in_rem    (chain_rem[j]),
            .in_sum    (chain_sum[j]),
            .divisor   (slot_size[j]),
            .stride    (slot_stride[j]),
            .out_valid (chain_valid[j+1]),
            .out_item  (chain_item[j+1]),
            .out_rem   (chain_rem[j+1]),
            .out_sum   (chain_sum[j+1])
        );
    end

    assign out_valid    = chain_valid[MAX_RANK];
    assign dest_index   = chain_item[MAX_RANK].lin;
    assign beyond_end   = chain_item[MAX_RANK].beyond;
    assign src_index    = beyond_end ? 32'd0
                        : 32'(chain_sum[MAX_RANK][INDEX_BITS-1:0]);
    assign overflow     = !beyond_end && (|chain_sum[MAX_RANK][SUM_BITS-1:INDEX_BITS]);

    `ASSERT_IMPLY(a_beyond_clean, clk, rst_n, out_valid && beyond_end,
        src_index == 32'd0 && !overflow, "beyond-end beat carries an address")
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(dest_index) && $stable(src_index), "stalled beat changed")
    `ASSERT_IMPLY(a_no_accept_on_stall, clk, rst_n, out_valid && !out_ready,
        !in_ready, "input taken while output stalled")

endmodule

@@ sv/sga_dim_unit.sv @@
// one dimension: pipelined divide by the dimension size, then digit times stride, accumulate
// depends on sga_pkg
module sga_dim_unit #(
    parameter int DIM_BITS = 16,
    parameter int SUM_BITS = 35
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          in_valid,
    input  sga_pkg::item_t                in_item,
    input  logic [sga_pkg::LIN_BITS-1:0]  in_rem,
    input  logic [SUM_BITS-1:0]           in_sum,
    input  logic [DIM_BITS-1:0]           divisor,
    input  logic [DIM_BITS-1:0]           stride,
    output logic                          out_valid,
    output sga_pkg::item_t                out_item,
    output logic [sga_pkg::LIN_BITS-1:0]  out_rem,
    output logic [SUM_BITS-1:0]           out_sum
);

    localparam int NS = sga_pkg::LIN_BITS / sga_pkg::DIV_STEP_BITS;
    localparam int LB = sga_pkg::LIN_BITS;

    logic                v_reg    [NS];
    sga_pkg::item_t      item_reg [NS];
    logic [DIM_BITS-1:0] r_reg    [NS];
    logic [LB-1:0]       q_reg    [NS];
    logic [SUM_BITS-1:0] sum_reg  [NS];

    logic                v_next    [NS];
    sga_pkg::item_t      item_next [NS];
    logic [DIM_BITS-1:0] r_next    [NS];
    logic [LB-1:0]       q_next    [NS];
    logic [SUM_BITS-1:0] sum_next  [NS];

    logic                mv_reg;
    sga_pkg::item_t      mitem_reg;
    logic [LB-1:0]       mq_reg;
    logic [SUM_BITS-1:0] msum_reg;
    logic [2*DIM_BITS-1:0] prod_reg;

    logic                av_reg;
    sga_pkg::item_t      aitem_reg;
    logic [LB-1:0]       aq_reg;
    logic [SUM_BITS-1:0] asum_reg;

    always_comb
    begin
        for (int s = 0; s < NS; s++)
        begin
            logic [DIM_BITS:0] t;
            logic [DIM_BITS-1:0] r;
            logic [LB-1:0] q;
            if (s == 0)
            begin
                v_next[s]    = in_valid;
                item_next[s] = in_item;
                r            = '0;
                q            = in_rem;
                sum_next[s]  = in_sum;
            end
            else
            begin
                v_next[s]    = v_reg[s-1];
                item_next[s] = item_reg[s-1];
                r            = r_reg[s-1];
                q            = q_reg[s-1];
                sum_next[s]  = sum_reg[s-1];
            end
            for (int k = 0; k < sga_pkg::DIV_STEP_BITS; k++)
            begin
                t = {r, q[LB-1]};
                q = {q[LB-2:0], 1'b0};
                if (t >= {1'b0, divisor})
                begin
                    t    = t - {1'b0, divisor};
                    q[0] = 1'b1;
                end
                r = t[DIM_BITS-1:0];
            end
            r_next[s] = r;
            q_next[s] = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            mv_reg <= 1'b0;
            av_reg <= 1'b0;
        end
        else if (advance)
        begin
            for (int s = 0; s < NS; s++)
            begin
                v_reg[s] <= v_next[s];
            end
            mv_reg <= v_reg[NS-1];
            av_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < NS; s++)
            begin
                item_reg[s] <= item_next[s];
                r_reg[s]    <= r_next[s];
                q_reg[s]    <= q_next[s];
                sum_reg[s]  <= sum_next[s];
            end
            mitem_reg <= item_reg[NS-1];
            mq_reg    <= q_reg[NS-1];
            msum_reg  <= sum_reg[NS-1];
            prod_reg  <= r_reg[NS-1] * stride;
            aitem_reg <= mitem_reg;
            aq_reg    <= mq_reg;
            asum_reg  <= msum_reg + SUM_BITS'(prod_reg);
        end
    end

    assign out_valid = av_reg;
    assign out_item  = aitem_reg;
    assign out_rem   = aq_reg;
    assign out_sum   = asum_reg;

endmodule

@@ tb/tb_strided_gather_address.sv @@
// testbench of the strided gather address generator: random and directed linear indices
// under several view configurations, results checked beat by beat against a local predictor
// depends on sga_pkg and strided_gather_address
`timescale 1ns / 100ps

module tb_strided_gather_address;

    localparam int LATENCY = 40;
    localparam longint LIMIT = 2000000;

    typedef struct {
        logic [31:0] dest;
        logic [31:0] src;
        logic        beyond;
        logic        ovf;
    } addr_t;

    typedef struct {
        bit                  is_cfg;
        sga_pkg::cfg_index_t idx;
        logic [63:0]         data;
        logic [31:0]         lin;
    } job_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] linear_index;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] dest_index;
    logic [31:0] src_index;
    logic        beyond_end;
    logic        overflow;

    logic [2:0]  v_rank;
    logic [63:0] v_shape;
    logic [63:0] v_stride;
    logic [31:0] v_base;
    logic [31:0] v_count;

    job_t   jobs[$];
    addr_t  expected_addrs[$];
    int     send_idle;
    int     recv_idle;
    bit     hold_send;
    int     errors;
    longint cycles;

    strided_gather_address i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .linear_index(linear_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .dest_index(dest_index), .src_index(src_index),
        .beyond_end(beyond_end), .overflow(overflow)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic addr_t gather_address(logic [31:0] lin);
        addr_t r;
        logic [63:0] sum;
        logic [31:0] rem;
        logic [15:0] size;
        logic [15:0] stride;
        int used;
        used = (v_rank > 4) ? 4 : int'(v_rank);
        rem = lin;
        sum = {32'd0, v_base};
        for (int d = used - 1; d >= 0; d--)
        begin
            size = v_shape[16*d +: 16];
            stride = v_stride[16*d +: 16];
            if (size == 0)
                size = 1;
            sum += 64'(rem % size) * 64'(stride);
            rem = rem / size;
        end
        r.dest = lin;
        r.beyond = (lin >= v_count);
        r.src = r.beyond ? 32'd0 : sum[31:0];
        r.ovf = r.beyond ? 1'b0 : (sum[63:32] != 0);
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            in_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
            linear_index <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (sga_pkg::cfg_index_t'(cfg_index))
                    sga_pkg::CFG_RANK:          v_rank = cfg_data[2:0];
                    sga_pkg::CFG_SHAPE:         v_shape = cfg_data;
                    sga_pkg::CFG_STRIDE:        v_stride = cfg_data;
                    sga_pkg::CFG_BASE_OFFSET:   v_base = cfg_data[31:0];
                    sga_pkg::CFG_ELEMENT_COUNT: v_count = cfg_data[31:0];
                    default: ;
                endcase
                jobs.pop_front();
            end
            if (in_valid && in_ready)
            begin
                expected_addrs.push_back(gather_address(linear_index));
                jobs.pop_front();
            end
            if ((cfg_valid && !cfg_ready) || (in_valid && !in_ready))
                ;
            else if (jobs.size() > 0 && !hold_send && $urandom_range(99) >= send_idle)
            begin
                if (jobs[0].is_cfg)
                begin
                    cfg_valid <= 1'b1;
                    in_valid <= 1'b0;
                    cfg_index <= jobs[0].idx;
                    cfg_data <= jobs[0].data;
                end
                else
                begin
                    cfg_valid <= 1'b0;
                    in_valid <= 1'b1;
                    linear_index <= jobs[0].lin;
                end
            end
            else
            begin
                cfg_valid <= 1'b0;
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_addrs.size() == 0)
                begin
                    $error("unexpected beat dest_index %0h", dest_index);
                    errors++;
                end
                else
                begin
                    addr_t e;
                    e = expected_addrs.pop_front();
                    if (dest_index !== e.dest)
                    begin
                        $error("dest_index expected %0h actual %0h", e.dest, dest_index);
                        errors++;
                    end
                    if (src_index !== e.src)
                    begin
                        $error("src_index expected %0h actual %0h", e.src, src_index);
                        errors++;
                    end
                    if (beyond_end !== e.beyond)
                    begin
                        $error("beyond_end expected %0b actual %0b", e.beyond, beyond_end);
                        errors++;
                    end
                    if (overflow !== e.ovf)
                    begin
                        $error("overflow expected %0b actual %0b", e.ovf, overflow);
                        errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("strided_gather_address test failed");
            $finish;
        end
    end

    task automatic add_cfg(sga_pkg::cfg_index_t idx, logic [63:0] data);
        job_t j;
        j.is_cfg = 1'b1;
        j.idx = idx;
        j.data = data;
        j.lin = '0;
        jobs.push_back(j);
    endtask

    task automatic add_index(logic [31:0] lin);
        job_t j;
        j.is_cfg = 1'b0;
        j.idx = sga_pkg::CFG_RANK;
        j.data = '0;
        j.lin = lin;
        jobs.push_back(j);
    endtask

    task automatic drain();
        wait (jobs.size() == 0);
        wait (expected_addrs.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic setup_view(logic [2:0] r, logic [63:0] sh, logic [63:0] st,
                              logic [31:0] b, logic [31:0] n);
        add_cfg(sga_pkg::CFG_RANK, {61'd0, r});
        add_cfg(sga_pkg::CFG_SHAPE, sh);
        add_cfg(sga_pkg::CFG_STRIDE, st);
        add_cfg(sga_pkg::CFG_BASE_OFFSET, {32'd0, b});
        add_cfg(sga_pkg::CFG_ELEMENT_COUNT, {32'd0, n});
    endtask

    function automatic logic [63:0] rand_dims(int maxv);
        logic [63:0] v;
        for (int d = 0; d < 4; d++)
            v[16*d +: 16] = 16'($urandom_range(maxv));
        return v;
    endfunction

    task automatic random_phase(int n_items);
        int kind;
        logic [63:0] sh;
        logic [63:0] st;
        logic [31:0] n;
        for (int k = 0; k < 7; k++)
        begin
            kind = $urandom_range(3);
            sh = (kind == 0) ? {$urandom, $urandom} : rand_dims(kind == 1 ? 9 : 300);
            st = (kind == 3) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom};
            n = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(20000));
            setup_view(3'($urandom_range(7)), sh, st,
                       ($urandom_range(1) == 1) ? $urandom
                                                : 32'($urandom_range(32'd4000000000, 32'd0)),
                       n);
            for (int i = 0; i < n_items / 7; i++)
            begin
                if ($urandom_range(3) == 0)
                    add_index($urandom);
                else
                    add_index(32'($urandom_range(n == 0 ? 0 : n - 1)));
            end
            drain();
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_send = 0;
        send_idle = 21;
        recv_idle = 46;
        v_rank = 3'd1;
        v_shape = 64'h0001_0001_0001_0001;
        v_stride = '0;
        v_base = '0;
        v_count = '0;
        cfg_valid = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        linear_index = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset view: every index lands beyond the end
        add_index(32'd0);
        add_index(32'hFFFF_FFFF);
        drain();
        // full 4-d view with extreme strides and overflow
        setup_view(3'd4, 64'h0003_0004_0005_0006, 64'hFFFF_FFFF_FFFF_FFFF,
                   32'hFFFF_FF00, 32'hFFFF_FFFF);
        add_index(32'd0);
        add_index(32'd1);
        add_index(32'd119);
        add_index(32'd120);
        add_index(32'hFFFF_FFFE);
        add_index(32'h5555_5555);
        add_index(32'hAAAA_AAAA);
        drain();
        // rank zero, zero sizes, rank above the maximum
        setup_view(3'd0, 64'h0, 64'h1234_5678_9ABC_DEF0, 32'h0000_1000, 32'd100);
        add_index(32'd5);
        add_index(32'd99);
        add_index(32'd100);
        drain();
        setup_view(3'd7, 64'h0000_0002_0000_FFFF, 64'h0001_0010_0100_1000,
                   32'd0, 32'hFFFF_FFFF);
        add_index(32'd0);
        add_index(32'hFFFF_FFFE);
        add_index(32'd70000);
        add_index(32'h8000_0000);
        drain();
        setup_view(3'd2, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0001_FFFF,
                   32'd0, 32'd0);
        add_index(32'd0);
        drain();

        random_phase(240);
        send_idle = 46;
        recv_idle = 21;
        random_phase(240);
        send_idle = 0;
        recv_idle = 0;
        random_phase(220);

        // stop sending with beats in flight until all of them are back
        for (int i = 0; i < 8; i++)
            add_index($urandom);
        wait (jobs.size() <= 4);
        hold_send = 1;
        wait (expected_addrs.size() == 0);
        hold_send = 0;
        drain();
        if (errors == 0)
            $display("strided_gather_address test passed");
        else
            $display("strided_gather_address test failed");
        $finish;
    end

endmodule

@@ strided_gather_address.f @@
+incdir+sv
sv/sga_pkg.sv
sv/sga_dim_unit.sv
sv/strided_gather_address.sv
tb/tb_strided_gather_address.sv
